@@ rtl/key_to_gamepad_event_mapper_macros.svh @@
// ----------------------------------------------------------------------------
// Key to gamepad event mapper - assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KEY_TO_GAMEPAD_EVENT_MAPPER_MACROS_SVH
`define KEY_TO_GAMEPAD_EVENT_MAPPER_MACROS_SVH

// same-cycle implication
`define KGEM_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("kgem assertion failed");

// next-cycle implication
`define KGEM_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("kgem assertion failed");

`endif

@@ rtl/kgem_pkg.sv @@
// ----------------------------------------------------------------------------
// kgem_pkg
// Types, codes and helpers shared by the key to gamepad event mapper.
// ----------------------------------------------------------------------------
package kgem_pkg;

	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic CFG_GAMEPAD     = 1'b0;
	localparam logic CFG_PASSTHROUGH = 1'b1;

	localparam logic [1:0] ACT_RELEASE = 2'd0;
	localparam logic [1:0] ACT_PRESS   = 2'd1;
	localparam logic [1:0] ACT_REPEAT  = 2'd2;

	localparam logic [1:0] EVT_SYN = 2'd0;
	localparam logic [1:0] EVT_KEY = 2'd1;
	localparam logic [1:0] EVT_ABS = 2'd2;

	localparam logic [7:0] KIND_BUTTON = 8'd1;
	localparam logic [7:0] KIND_AXIS   = 8'd2;
	localparam logic [7:0] KIND_DPAD   = 8'd3;

	localparam logic [15:0] BTN_TL2      = 16'h0138;
	localparam logic [15:0] BTN_TR2      = 16'h0139;
	localparam logic [15:0] BTN_HAT_UP   = 16'h0220;
	localparam logic [15:0] BTN_HAT_RIGHT = 16'h0223;

	localparam logic [15:0] ABS_X      = 16'h0000;
	localparam logic [15:0] ABS_Y      = 16'h0001;
	localparam logic [15:0] ABS_Z      = 16'h0002;
	localparam logic [15:0] ABS_RX     = 16'h0003;
	localparam logic [15:0] ABS_RY     = 16'h0004;
	localparam logic [15:0] ABS_RZ     = 16'h0005;
	localparam logic [15:0] HAT_X_CODE = 16'h0010;
	localparam logic [15:0] HAT_Y_CODE = 16'h0011;

	localparam logic [15:0] DPAD_UP_KEY = 16'd103;
	localparam logic [15:0] DPAD_DN_KEY = 16'd108;
	localparam logic [15:0] DPAD_LT_KEY = 16'd105;
	localparam logic [15:0] DPAD_RT_KEY = 16'd106;

	localparam logic [15:0] DPAD_ALT_TARGET = 16'd1;

	localparam logic signed [31:0] TRIGGER_MAX = 32'sd255;
	localparam logic signed [31:0] HAT_MAG     = 32'sd1;
	localparam logic signed [31:0] DPAD_MAG    = 32'sd32767;

	// direction bits: 0 up, 1 down, 2 left, 3 right
	localparam int DIR_UP    = 0;
	localparam int DIR_DOWN  = 1;
	localparam int DIR_LEFT  = 2;
	localparam int DIR_RIGHT = 3;

	typedef struct packed {
		logic [15:0]        key;
		logic [15:0]        target;
		logic [7:0]         kind;
		logic signed [31:0] amount;
	} kgem_entry_t;

	typedef struct packed {
		logic       take;
		logic       scan;
		logic       upd;
		logic       emit;
		logic       pt;
		logic [1:0] slot;
	} kgem_cmd_t;

	typedef struct packed {
		logic       in_load;
		logic       hit;
		logic       miss;
		logic       go;
		logic       pt_en;
		logic       out_free;
		logic [1:0] sync_slot;
	} kgem_sts_t;

	function automatic logic signed [31:0] axis_x(input logic [3:0] bits,
		input logic signed [31:0] mag);
		logic signed [31:0] v;
		v = '0;
		if (bits[DIR_RIGHT])
			v = mag;
		else if (bits[DIR_LEFT])
			v = 32'sd0 - mag;
		return v;
	endfunction

	function automatic logic signed [31:0] axis_y(input logic [3:0] bits,
		input logic signed [31:0] mag);
		logic signed [31:0] v;
		v = '0;
		if (bits[DIR_DOWN])
			v = mag;
		else if (bits[DIR_UP])
			v = 32'sd0 - mag;
		return v;
	endfunction

endpackage

@@ rtl/kgem_ram.sv @@
// ----------------------------------------------------------------------------
// kgem_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kgem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/kgem_ctrl.sv @@
// ----------------------------------------------------------------------------
// kgem_ctrl
// Sequencer: accept item, scan table, update direction bits, emit events.
// ----------------------------------------------------------------------------
`include "key_to_gamepad_event_mapper_macros.svh"

module kgem_ctrl
	import kgem_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  kgem_sts_t sts,
	output kgem_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] slot_q;
	logic       pt_q;
	logic       take;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid & in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && sts.in_load == CMD_KEY)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.hit)
					state_d = ST_UPD;
				else if (sts.miss)
					state_d = sts.pt_en ? ST_EMIT : ST_IDLE;
			end
			ST_UPD: begin
				state_d = sts.go ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (sts.out_free && slot_q == sts.sync_slot)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			pt_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				slot_q <= '0;
				pt_q   <= 1'b0;
			end else if (state_q == ST_SCAN && sts.miss && !sts.hit) begin
				pt_q <= 1'b1;
			end else if (state_q == ST_EMIT && sts.out_free) begin
				slot_q <= slot_q + 2'd1;
			end
		end
	end

	always_comb begin
		cmd.take = take;
		cmd.scan = (state_q == ST_SCAN);
		cmd.upd  = (state_q == ST_UPD);
		cmd.emit = (state_q == ST_EMIT) && sts.out_free;
		cmd.pt   = pt_q;
		cmd.slot = slot_q;
	end

	`KGEM_ASSERT_IMP(a_hit_miss_excl, sts.hit, !sts.miss)
	`KGEM_ASSERT_IMP(a_emit_free, cmd.emit, sts.out_free)
	`KGEM_ASSERT_NXT(a_key_scans, take && sts.in_load == CMD_KEY, state_q == ST_SCAN)
	`KGEM_ASSERT_NXT(a_sync_ends, cmd.emit && cmd.slot == sts.sync_slot, in_ready)
	`KGEM_ASSERT_IMP(a_slot_bound, state_q == ST_EMIT, slot_q <= sts.sync_slot)

endmodule

@@ rtl/kgem_dp.sv @@
// ----------------------------------------------------------------------------
// kgem_dp
// Datapath: mapping table, scan pointer, direction bits, event output register.
// ----------------------------------------------------------------------------
module kgem_dp
	import kgem_pkg::*;
#(
	parameter int TABLE_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic               cfg_wdata,
	input  logic               cmd_in,
	input  logic [15:0]        key_code,
	input  logic [1:0]         key_action,
	input  logic               restart_load,
	input  logic [15:0]        entry_target_code,
	input  logic [7:0]         entry_kind,
	input  logic signed [31:0] entry_amount,
	input  kgem_cmd_t          cmd,
	output kgem_sts_t          sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         event_type,
	output logic [15:0]        event_code,
	output logic signed [31:0] event_value,
	output logic               to_passthrough,
	output logic               last
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

	logic          gamepad_q, pass_en_q;
	logic [CW-1:0] count_q, rd_ptr_q, base;
	logic          cmp_vld_q;
	logic [15:0]   key_q;
	logic [1:0]    action_q;
	logic [3:0]    hat_q, dpad_q;
	logic          wr_en, rd_en, pressed, is_hat, out_vld_q;
	kgem_entry_t   wr_ent, rd_ent;

	logic [1:0]         ev_type;
	logic [15:0]        ev_code;
	logic signed [31:0] ev_val;

	assign base   = restart_load ? '0 : count_q;
	assign wr_en  = cmd.take && cmd_in == CMD_LOAD && base != FULL;
	assign wr_ent = '{key: key_code, target: entry_target_code, kind: entry_kind,
		amount: entry_amount};
	assign rd_en  = cmd.scan && !sts.hit && rd_ptr_q < count_q;

	kgem_ram #(
		.WIDTH($bits(kgem_entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(base[AW-1:0]),
		.wdata(wr_ent),
		.re   (rd_en),
		.raddr(rd_ptr_q[AW-1:0]),
		.rdata(rd_ent)
	);

	assign pressed = (action_q == ACT_PRESS) || (action_q == ACT_REPEAT);
	assign is_hat  = rd_ent.target >= BTN_HAT_UP && rd_ent.target <= BTN_HAT_RIGHT;

	always_comb begin
		sts.in_load  = cmd_in;
		sts.hit      = cmp_vld_q && rd_ent.key == key_q;
		sts.miss     = !cmp_vld_q && rd_ptr_q == count_q;
		sts.go       = gamepad_q && (rd_ent.kind == KIND_BUTTON ||
			rd_ent.kind == KIND_AXIS || rd_ent.kind == KIND_DPAD);
		sts.pt_en    = pass_en_q;
		sts.out_free = !out_vld_q || out_ready;
		if (cmd.pt)
			sts.sync_slot = 2'd1;
		else if (rd_ent.kind == KIND_DPAD || (rd_ent.kind == KIND_BUTTON && is_hat))
			sts.sync_slot = 2'd2;
		else
			sts.sync_slot = 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamepad_q <= 1'b0;
			pass_en_q <= 1'b1;
			count_q   <= '0;
			rd_ptr_q  <= '0;
			cmp_vld_q <= 1'b0;
			hat_q     <= '0;
			dpad_q    <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == CFG_GAMEPAD)
					gamepad_q <= cfg_wdata;
				else
					pass_en_q <= cfg_wdata;
			end
			if (cmd.take) begin
				rd_ptr_q  <= '0;
				cmp_vld_q <= 1'b0;
				if (cmd_in == CMD_LOAD)
					count_q <= wr_en ? base + CW'(1) : base;
			end else if (cmd.scan && !sts.hit) begin
				cmp_vld_q <= rd_en;
				if (rd_en)
					rd_ptr_q <= rd_ptr_q + CW'(1);
			end
			if (cmd.upd) begin
				if (rd_ent.kind == KIND_BUTTON && is_hat)
					hat_q[rd_ent.target[1:0]] <= pressed;
				if (rd_ent.kind == KIND_DPAD) begin
					if (key_q == DPAD_UP_KEY)
						dpad_q[DIR_UP] <= pressed;
					else if (key_q == DPAD_DN_KEY)
						dpad_q[DIR_DOWN] <= pressed;
					else if (key_q == DPAD_LT_KEY)
						dpad_q[DIR_LEFT] <= pressed;
					else if (key_q == DPAD_RT_KEY)
						dpad_q[DIR_RIGHT] <= pressed;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			key_q    <= key_code;
			action_q <= key_action;
		end
	end

	always_comb begin
		ev_type = EVT_SYN;
		ev_code = '0;
		ev_val  = '0;
		if (cmd.slot == sts.sync_slot) begin
			ev_type = EVT_SYN;
		end else if (cmd.pt) begin
			ev_type = EVT_KEY;
			ev_code = key_q;
			ev_val  = {30'd0, action_q};
		end else begin
			case (rd_ent.kind)
				KIND_BUTTON: begin
					ev_type = EVT_ABS;
					if (rd_ent.target == BTN_TL2) begin
						ev_code = ABS_Z;
						ev_val  = pressed ? TRIGGER_MAX : '0;
					end else if (rd_ent.target == BTN_TR2) begin
						ev_code = ABS_RZ;
						ev_val  = pressed ? TRIGGER_MAX : '0;
					end else if (is_hat) begin
						ev_code = (cmd.slot == 2'd0) ? HAT_X_CODE : HAT_Y_CODE;
						ev_val  = (cmd.slot == 2'd0) ? axis_x(hat_q, HAT_MAG) :
							axis_y(hat_q, HAT_MAG);
					end else begin
						ev_type = EVT_KEY;
						ev_code = rd_ent.target;
						ev_val  = {31'd0, pressed};
					end
				end
				KIND_AXIS: begin
					ev_type = EVT_ABS;
					ev_code = rd_ent.target;
					ev_val  = pressed ? rd_ent.amount : '0;
				end
				KIND_DPAD: begin
					ev_type = EVT_ABS;
					if (cmd.slot == 2'd0) begin
						ev_code = (rd_ent.target == DPAD_ALT_TARGET) ? ABS_RX : ABS_X;
						ev_val  = axis_x(dpad_q, DPAD_MAG);
					end else begin
						ev_code = (rd_ent.target == DPAD_ALT_TARGET) ? ABS_RY : ABS_Y;
						ev_val  = axis_y(dpad_q, DPAD_MAG);
					end
				end
				default: begin
					ev_type = EVT_SYN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.emit)
			out_vld_q <= 1'b1;
		else if (out_ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			event_type     <= ev_type;
			event_code     <= ev_code;
			event_value    <= ev_val;
			to_passthrough <= cmd.pt;
			last           <= (cmd.slot == sts.sync_slot);
		end
	end

	assign out_valid = out_vld_q;

endmodule

@@ rtl/key_to_gamepad_event_mapper.sv @@
// ----------------------------------------------------------------------------
// key_to_gamepad_event_mapper
// Maps key events to gamepad events through a loadable table.
//
// Input channel (in_valid/in_ready): cmd selects a key event or a table load.
// A load appends one entry (restart_load empties the table first);
// entries beyond TABLE_DEPTH are dropped and nothing is emitted.
// A key event scans the table linearly, one entry per cycle through the
// registered read port of the table RAM.
// Output channel (out_valid/out_ready) carries none, two or three events per key,
// the final sync marked by last. Events sit in an output register; a stall on
// out_ready holds the sequencer, and in_ready returns once the sync has been
// loaded into that register.
// Config port: cfg_we writes cfg_wdata to register cfg_idx (0 gamepad
// present, 1 passthrough enable) at any clock edge.
// Reset empties the table (entry count to zero), clears the direction bits
// and out_valid; gamepad present resets to 0, passthrough enable to 1.
// ----------------------------------------------------------------------------
module key_to_gamepad_event_mapper
	import kgem_pkg::*;
#(
	parameter int TABLE_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [15:0]        key_code,
	input  logic [1:0]         key_action,
	input  logic               restart_load,
	input  logic [15:0]        entry_target_code,
	input  logic [7:0]         entry_kind,
	input  logic signed [31:0] entry_amount,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         event_type,
	output logic [15:0]        event_code,
	output logic signed [31:0] event_value,
	output logic               to_passthrough,
	output logic               last
);

	kgem_cmd_t ctl_cmd;
	kgem_sts_t dp_sts;

	kgem_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (dp_sts),
		.cmd     (ctl_cmd)
	);

	kgem_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata),
		.cmd_in           (cmd),
		.key_code         (key_code),
		.key_action       (key_action),
		.restart_load     (restart_load),
		.entry_target_code(entry_target_code),
		.entry_kind       (entry_kind),
		.entry_amount     (entry_amount),
		.cmd              (ctl_cmd),
		.sts              (dp_sts),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.event_type       (event_type),
		.event_code       (event_code),
		.event_value      (event_value),
		.to_passthrough   (to_passthrough),
		.last             (last)
	);

endmodule
